// File: rtl/nfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg: shared definitions of the next-fit page bump allocator
// Field widths, default geometry, command and register codes, the
// configuration and queue entry types and the back end state type.
// ----------------------------------------------------------------------------
package nfa_pkg;

	// fixed field widths
	localparam int SIZE_W = 19;
	localparam int ADDR_W = 32;
	localparam int PCNT_W = 7;

	// default geometry
	localparam int DEF_MAX_PAGES    = 64;
	localparam int DEF_PAGE_BYTES   = 262144;
	localparam int DEF_HEADER_BYTES = 64;

	// request commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_PAGES = 1'b1;

	// live configuration, base already aligned to a page
	typedef struct packed {
		logic [ADDR_W-1:0] aligned_base;
		logic [PCNT_W-1:0] page_count;
	} cfg_t;

	// classified request as it waits between front and back
	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0] size;
		logic              q_in;
		logic [ADDR_W-1:0] q_rel;
	} entry_t;

	// back end status seen by the top level
	typedef struct packed {
		logic clearing;
	} bk_status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_QCHK
	} bk_state_t;

	// page count register mapped onto the usable range
	function automatic int pages_in_use(logic [PCNT_W-1:0] pc, int max_pages);
		int v;
		v = int'(pc);
		if (v == 0) begin
			return 1;
		end
		if (v > max_pages) begin
			return max_pages;
		end
		return v;
	endfunction

endpackage

// File: rtl/nfa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_req_if: request channel
// Valid/ready channel carrying one allocate or contains request.
// ----------------------------------------------------------------------------
interface nfa_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [18:0] alloc_size;
	logic [31:0] query_address;

	modport source (output valid, output command, output alloc_size, output query_address,
		input ready);
	modport sink (input valid, input command, input alloc_size, input query_address,
		output ready);
endinterface

// File: rtl/nfa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_rsp_if: response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface nfa_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] address;

	modport source (output valid, output ok, output address, input ready);
	modport sink (input valid, input ok, input address, output ready);
endinterface

// File: rtl/nfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_front: request intake and classification
// Takes requests, works out where a query address falls in the region and
// holds classified requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nfa_front #(
	parameter int MAX_PAGES    = nfa_pkg::DEF_MAX_PAGES,
	parameter int PAGE_BYTES   = nfa_pkg::DEF_PAGE_BYTES,
	parameter int HEADER_BYTES = nfa_pkg::DEF_HEADER_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	nfa_req_if.sink        req,
	input  nfa_pkg::cfg_t  cfg,
	input  logic           hold,
	input  logic           pop,
	output logic           q_valid,
	output nfa_pkg::entry_t q_entry
);
	import nfa_pkg::*;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);

	logic [CNT_W-1:0]      n_pages;
	logic [ADDR_W+1:0]     base_w;
	logic [ADDR_W+1:0]     end_w;
	logic [ADDR_W+1:0]     q_w;
	logic [ADDR_W-1:0]     rel;
	logic [PAGE_SHIFT-1:0] off;
	logic                  in_range;
	logic                  hdr_ok;
	logic                  push;
	entry_t                ent_new;
	entry_t                ent_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	// region bounds, computed without wrap-around
	assign n_pages  = CNT_W'(pages_in_use(cfg.page_count, MAX_PAGES));
	assign base_w   = {2'b00, cfg.aligned_base};
	assign end_w    = base_w + ((ADDR_W + 2)'(n_pages) << PAGE_SHIFT);
	assign q_w      = {2'b00, req.query_address};
	assign in_range = (q_w >= base_w) && (q_w < end_w);

	// offset inside the page must be past the header
	assign rel    = req.query_address - cfg.aligned_base;
	assign off    = rel[PAGE_SHIFT-1:0];
	assign hdr_ok = ADDR_W'(off) >= ADDR_W'(HEADER_BYTES);

	always_comb begin
		ent_new.cmd   = req.command;
		ent_new.size  = req.alloc_size;
		ent_new.q_in  = in_range && hdr_ok;
		ent_new.q_rel = rel;
	end

	// queue handshake
	assign req.ready = (count_q != 2'd2) && !hold;
	assign push      = req.valid && req.ready;
	assign q_valid   = count_q != 2'd0;
	assign q_entry   = ent_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= ent_new;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/nfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_back: page fill store and request sequencer
// Holds the fill offset of every page, clears it on demand, walks the ring
// one page per cycle for an allocate and answers contains queries.
// ----------------------------------------------------------------------------
module nfa_back #(
	parameter int MAX_PAGES    = nfa_pkg::DEF_MAX_PAGES,
	parameter int PAGE_BYTES   = nfa_pkg::DEF_PAGE_BYTES,
	parameter int HEADER_BYTES = nfa_pkg::DEF_HEADER_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nfa_pkg::cfg_t      cfg,
	input  logic               clear,
	input  logic               q_valid,
	input  nfa_pkg::entry_t    q_entry,
	output logic               pop,
	output nfa_pkg::bk_status_t status,
	nfa_rsp_if.source          rsp
);
	import nfa_pkg::*;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);
	localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FILL_W     = $clog2(PAGE_BYTES + 1);
	localparam int SUM_W      = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;

	// fill store
	logic [FILL_W-1:0] fill_mem [MAX_PAGES];
	logic [FILL_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [FILL_W-1:0] mem_wdata;

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  p_q;
	logic [CNT_W-1:0]  k_q;
	logic [SIZE_W-1:0] size_q;
	logic [PAGE_SHIFT-1:0] off_q;

	logic              out_valid_q;
	logic              out_ok_q;
	logic [ADDR_W-1:0] out_addr_q;

	logic [CNT_W-1:0]  n_pages;
	logic              slot_free;
	logic [SUM_W-1:0]  sum;
	logic              fit;
	logic              last;
	logic [CNT_W-1:0]  p_inc;
	logic [IDX_W-1:0]  p_next;
	logic [IDX_W-1:0]  q_page;
	logic [ADDR_W-1:0] alloc_addr;
	logic              clr_done;
	logic              res_set;
	logic              res_ok;
	logic [ADDR_W-1:0] res_addr;

	// datapath around the probed page
	assign n_pages    = CNT_W'(pages_in_use(cfg.page_count, MAX_PAGES));
	assign slot_free  = !out_valid_q || rsp.ready;
	assign sum        = SUM_W'(rd_data_q) + SUM_W'(size_q);
	assign fit        = sum <= SUM_W'(PAGE_BYTES);
	assign last       = k_q == (n_pages - CNT_W'(1));
	assign p_inc      = CNT_W'(p_q) + CNT_W'(1);
	assign p_next     = (p_inc == n_pages) ? '0 : IDX_W'(p_inc);
	assign q_page     = IDX_W'(q_entry.q_rel >> PAGE_SHIFT);
	assign alloc_addr = cfg.aligned_base + (ADDR_W'(p_q) << PAGE_SHIFT) + ADDR_W'(rd_data_q);
	assign clr_done   = clr_cnt_q == IDX_W'(MAX_PAGES - 1);
	assign status.clearing = state_q == ST_CLEAR;

	// next state
	always_comb begin
		state_d = state_q;
		if (clear) begin
			state_d = ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_done) begin
						state_d = ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid && slot_free) begin
						if (q_entry.cmd == CMD_ALLOC) begin
							state_d = ST_SCAN;
						end else if (q_entry.q_in) begin
							state_d = ST_QCHK;
						end
					end
				end
				ST_SCAN: begin
					if (fit || last) begin
						state_d = ST_IDLE;
					end
				end
				ST_QCHK: state_d = ST_IDLE;
				default: state_d = ST_CLEAR;
			endcase
		end
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		rd_addr   = p_q;
		mem_we    = 1'b0;
		mem_waddr = p_q;
		mem_wdata = FILL_W'(sum);
		res_set   = 1'b0;
		res_ok    = 1'b0;
		res_addr  = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = FILL_W'(HEADER_BYTES);
			end
			ST_IDLE: begin
				if (q_valid && slot_free) begin
					pop = 1'b1;
					if (q_entry.cmd == CMD_ALLOC) begin
						rd_addr = cur_q;
					end else if (q_entry.q_in) begin
						rd_addr = q_page;
					end else begin
						res_set = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (fit) begin
					mem_we   = 1'b1;
					res_set  = 1'b1;
					res_ok   = 1'b1;
					res_addr = alloc_addr;
				end else if (last) begin
					res_set = 1'b1;
				end else begin
					rd_addr = p_next;
				end
			end
			ST_QCHK: begin
				res_set = 1'b1;
				res_ok  = FILL_W'(off_q) < rd_data_q;
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	// fill store ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			fill_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= fill_mem[rd_addr];
	end

	// request payload held during the walk
	always_ff @(posedge clk) begin
		if (pop) begin
			size_q <= q_entry.size;
			off_q  <= q_entry.q_rel[PAGE_SHIFT-1:0];
		end
		if (res_set) begin
			out_ok_q   <= res_ok;
			out_addr_q <= res_addr;
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			cur_q       <= '0;
			p_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				clr_cnt_q <= '0;
				cur_q     <= '0;
			end else begin
				if (state_q == ST_CLEAR) begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
				end
				if (state_q == ST_SCAN && fit) begin
					cur_q <= p_q;
				end
			end
			if (state_q == ST_IDLE) begin
				p_q <= cur_q;
				k_q <= '0;
			end else if (state_q == ST_SCAN) begin
				p_q <= p_next;
				k_q <= k_q + CNT_W'(1);
			end
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response channel
	assign rsp.valid   = out_valid_q;
	assign rsp.ok      = out_ok_q;
	assign rsp.address = out_addr_q;

endmodule

// File: rtl/next_fit_page_bump_allocator.sv
`timescale 1ns / 1ps
// Allocate: ST_IDLE pops the request and reads the cursor page fill; ST_SCAN probes one
//   page per cycle, up to the page count; a new request is popped only back in ST_IDLE.
// Contains: answered in ST_IDLE if outside the ring or in a page header, else in ST_QCHK.
// Reset and every register write start a clearing pass over all MAX_PAGES fill entries;
//   no request is taken during it. PAGE_BYTES must be a power of two; it is not checked.
// ----------------------------------------------------------------------------
// next_fit_page_bump_allocator: next-fit bump allocator over a ring of pages
// Front end classifies requests into a short queue, back end walks the page
// ring, bumps the fill of the first page that fits and answers queries.
// ----------------------------------------------------------------------------
module next_fit_page_bump_allocator #(
	parameter int MAX_PAGES    = nfa_pkg::DEF_MAX_PAGES,
	parameter int PAGE_BYTES   = nfa_pkg::DEF_PAGE_BYTES,
	parameter int HEADER_BYTES = nfa_pkg::DEF_HEADER_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [nfa_pkg::ADDR_W-1:0] cfg_data,
	nfa_req_if.sink                   req,
	nfa_rsp_if.source                 rsp
);
	import nfa_pkg::*;

	logic [ADDR_W-1:0] base_q;
	logic [PCNT_W-1:0] pages_q;
	cfg_t              cfg;
	bk_status_t        status;
	logic              hold;
	logic              pop;
	logic              q_valid;
	entry_t            q_entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pages_q <= PCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_PAGES: pages_q <= cfg_data[PCNT_W-1:0];
				default:   base_q  <= base_q;
			endcase
		end
	end

	always_comb begin
		cfg.aligned_base = base_q & ~ADDR_W'(PAGE_BYTES - 1);
		cfg.page_count   = pages_q;
	end

	// no intake while the store is cleared or rewritten
	assign hold = status.clearing || cfg_we;

	nfa_front #(
		.MAX_PAGES    (MAX_PAGES),
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg     (cfg),
		.hold    (hold),
		.pop     (pop),
		.q_valid (q_valid),
		.q_entry (q_entry)
	);

	nfa_back #(
		.MAX_PAGES    (MAX_PAGES),
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.clear   (cfg_we),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.status  (status),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	// no request is taken while the fill store is being cleared
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !req.ready)
		else $error("request taken during clearing pass");

	// the back end only pops a queued request
	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	// a register write always starts a clearing pass
	a_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> status.clearing)
		else $error("register write did not clear pages");
`endif

endmodule
